[src/lgb_pkg.sv]
// Package for the Lorentz factor block: field widths, word types and
// per-cell state types. No dependencies.
package lgb_pkg;

	localparam int MW   = 24;          // momentum / mass width
	localparam int FB   = 16;          // fraction bits of the results
	localparam int GW   = 32;          // gamma field width
	localparam int BW   = 16;          // beta field width
	localparam int SQW  = 2 * MW;      // one square
	localparam int DW   = 2 * MW + 2;  // sum of squares plus mass square
	localparam int RW   = DW + 1;      // divider remainder
	localparam int QW   = 2 * GW;      // quotient bits per lane
	localparam int SRW  = GW + 2;      // root remainder
	localparam int NDIV = QW;          // divide cells per lane
	localparam int NSQ  = GW;          // root cells per lane
	localparam int NSTG = NDIV + NSQ;  // cells per lane
	localparam int NFE  = 5;           // front end stages

	typedef struct packed {
		logic signed [MW-1:0] momentum_x;
		logic signed [MW-1:0] momentum_y;
		logic signed [MW-1:0] momentum_z;
		logic        [MW-1:0] rest_mass;
	} in_word_t;

	typedef struct packed {
		logic [GW-1:0] gamma_q;
		logic [BW-1:0] beta_q;
		logic          mass_zero;
	} out_word_t;

	// restoring divider cell state
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [DW-1:0] dsor;
		logic [QW-1:0] dvd;
		logic [QW-1:0] quo;
	} div_t;

	// restoring square root cell state
	typedef struct packed {
		logic [SRW-1:0] rem;
		logic [GW-1:0]  root;
		logic [QW-1:0]  rad;
	} sqrt_t;

endpackage

[src/lorentz_gamma_beta.sv]
// Top level: front end (magnitudes, squares, sums), two cell lanes for
// gamma and beta, flag line and result word. Depends on lgb_pkg, lgb_lane.
//
//  channel  | valid        | stall        | word
//  ---------+--------------+--------------+------------------------------
//  items    | item_valid   | item_stall   | item   (momenta, rest mass)
//  results  | result_valid | result_stall | result (gamma, beta, flag)
//
// One word per cycle while no valid result is stalled; each word passes the
// front end stages, then 64 divider cells and 32 root cells per lane.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole row; bubbles still shift while the
// result side is free, and item_stall follows result stall of a valid word.
module lorentz_gamma_beta (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lgb_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output lgb_pkg::out_word_t result
);
	import lgb_pkg::*;

	localparam logic [GW-1:0] GAMMA_SAT = '1;
	localparam logic [BW-1:0] BETA_MAX  = BW'((64'd1 << FB) - 64'd1);
	localparam logic [GW-1:0] GAMMA_ONE = GW'(64'd1 << FB);

	logic en;

	logic [MW-1:0]  ax_s1, ay_s1, az_s1, m_s1;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2, m2_s2;
	logic [DW-1:0]  p2_s3, m2_s3, p2_s4, m2_s4, s_s4;
	logic [DW-1:0]  p2_s5, m2_s5, s_s5;
	logic           mz_s1, mz_s2, mz_s3, mz_s4, mz_s5, sat_s5;
	logic [NFE-1:0] fv_q;
	logic [NSTG-1:0] vld_q, mz_q, sat_q;

	logic [DW+QW-1:0] g_wide, b_wide, sat_ref;
	div_t             g_head, b_head;
	logic [GW-1:0]    g_root, b_root;

	// whole row advances unless a valid result is held
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// front end: magnitudes, squares, sums, saturation test
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= item.momentum_x[MW-1] ? -item.momentum_x : item.momentum_x;
			ay_s1 <= item.momentum_y[MW-1] ? -item.momentum_y : item.momentum_y;
			az_s1 <= item.momentum_z[MW-1] ? -item.momentum_z : item.momentum_z;
			m_s1  <= item.rest_mass;
			mz_s1 <= item.rest_mass == '0;
			sx_s2 <= ax_s1 * ax_s1;
			sy_s2 <= ay_s1 * ay_s1;
			sz_s2 <= az_s1 * az_s1;
			m2_s2 <= m_s1 * m_s1;
			mz_s2 <= mz_s1;
			p2_s3 <= DW'(sx_s2) + DW'(sy_s2) + DW'(sz_s2);
			m2_s3 <= DW'(m2_s2);
			mz_s3 <= mz_s2;
			p2_s4 <= p2_s3;
			m2_s4 <= m2_s3;
			s_s4  <= p2_s3 + m2_s3;
			mz_s4 <= mz_s3;
			p2_s5 <= p2_s4;
			m2_s5 <= m2_s4;
			s_s5  <= s_s4;
			mz_s5 <= mz_s4;
			sat_s5 <= {{QW{1'b0}}, s_s4} >= sat_ref;
		end
	end

	// gamma overflows when s >= m2 * 2^(64 - 2*FB)
	assign sat_ref = {{QW{1'b0}}, m2_s4} << (QW - 2 * FB);

	// lane heads: dividend scaled by 2^(2*FB), top part is the first remainder
	always_comb begin
		g_wide = {{QW{1'b0}}, s_s5} << (2 * FB);
		b_wide = {{QW{1'b0}}, p2_s5} << (2 * FB);
		g_head.rem  = {1'b0, g_wide[DW+QW-1:QW]};
		g_head.dsor = m2_s5;
		g_head.dvd  = g_wide[QW-1:0];
		g_head.quo  = '0;
		b_head.rem  = {1'b0, b_wide[DW+QW-1:QW]};
		b_head.dsor = s_s5;
		b_head.dvd  = b_wide[QW-1:0];
		b_head.quo  = '0;
	end

	lgb_lane u_gamma (
		.clk  (clk),
		.en   (en),
		.head (g_head),
		.root (g_root)
	);

	lgb_lane u_beta (
		.clk  (clk),
		.en   (en),
		.head (b_head),
		.root (b_root)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q  <= '0;
			vld_q <= '0;
		end else if (en) begin
			fv_q  <= {fv_q[NFE-2:0], item_valid};
			vld_q <= {vld_q[NSTG-2:0], fv_q[NFE-1]};
		end
	end

	// flags ride alongside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			mz_q  <= {mz_q[NSTG-2:0], mz_s5};
			sat_q <= {sat_q[NSTG-2:0], sat_s5};
		end
	end

	// result word
	assign result_valid = vld_q[NSTG-1];
	always_comb begin
		result.mass_zero = mz_q[NSTG-1];
		if (mz_q[NSTG-1]) begin
			result.gamma_q = GAMMA_SAT;
			result.beta_q  = BETA_MAX;
		end else begin
			result.gamma_q = sat_q[NSTG-1] ? GAMMA_SAT : g_root;
			result.beta_q  = b_root[BW-1:0];
		end
	end

	a_stall_rel: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item stall does not follow held result");

	a_gamma_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.mass_zero |-> result.gamma_q >= GAMMA_ONE)
		else $error("gamma below one");

	a_beta_lt_gamma: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.mass_zero |-> GW'(result.beta_q) < result.gamma_q)
		else $error("beta not below gamma");

endmodule

[src/lgb_div_cell.sv]
// One quotient bit of a restoring divider, registered.
// Depends on lgb_pkg.
module lgb_div_cell (
	input  logic          clk,
	input  logic          en,
	input  lgb_pkg::div_t prev,
	output lgb_pkg::div_t cur
);
	import lgb_pkg::*;

	logic [RW:0]   trial;
	logic          ge;
	logic [RW:0]   diff;
	div_t          nxt;
	div_t          cur_q;

	// bring down one dividend bit, subtract when it fits
	always_comb begin
		trial = {prev.rem, prev.dvd[QW-1]};
		ge    = trial >= {2'b00, prev.dsor};
		diff  = trial - {2'b00, prev.dsor};
		nxt.dsor = prev.dsor;
		nxt.dvd  = {prev.dvd[QW-2:0], 1'b0};
		nxt.quo  = {prev.quo[QW-2:0], ge};
		nxt.rem  = ge ? diff[RW-1:0] : trial[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_q <= nxt;
		end
	end

	assign cur = cur_q;
endmodule

[src/lgb_sqrt_cell.sv]
// One root bit of a restoring integer square root, registered.
// Depends on lgb_pkg.
module lgb_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  lgb_pkg::sqrt_t prev,
	output lgb_pkg::sqrt_t cur
);
	import lgb_pkg::*;

	logic [SRW+1:0] acc;
	logic [SRW+1:0] trial;
	logic           ge;
	logic [SRW+1:0] diff;
	sqrt_t          nxt;
	sqrt_t          cur_q;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		acc   = {prev.rem, prev.rad[QW-1:QW-2]};
		trial = {2'b00, prev.root, 2'b01};
		ge    = acc >= trial;
		diff  = acc - trial;
		nxt.rad  = {prev.rad[QW-3:0], 2'b00};
		nxt.root = {prev.root[GW-2:0], ge};
		nxt.rem  = ge ? diff[SRW-1:0] : acc[SRW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_q <= nxt;
		end
	end

	assign cur = cur_q;
endmodule

[src/lgb_lane.sv]
// Row of divider cells followed by root cells: isqrt(floor(num/den)).
// Depends on lgb_pkg, lgb_div_cell, lgb_sqrt_cell.
module lgb_lane (
	input  logic              clk,
	input  logic              en,
	input  lgb_pkg::div_t     head,
	output logic [lgb_pkg::GW-1:0] root
);
	import lgb_pkg::*;

	div_t  dchain [NDIV+1];
	sqrt_t schain [NSQ+1];

	assign dchain[0] = head;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		lgb_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.prev (dchain[i]),
			.cur  (dchain[i+1])
		);
	end

	// quotient becomes the radicand
	assign schain[0] = {{SRW{1'b0}}, {GW{1'b0}}, dchain[NDIV].quo};

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		lgb_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.prev (schain[i]),
			.cur  (schain[i+1])
		);
	end

	assign root = schain[NSQ].root;
endmodule
